/* src/key_debounce_remap_idle_dim_macros.svh */
// ----------------------------------------------------------------------------
// key debounce remap idle dim assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_REMAP_IDLE_DIM_MACROS_SVH
`define KEY_DEBOUNCE_REMAP_IDLE_DIM_MACROS_SVH

`ifndef SYNTHESIS
`define KDRID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");
`define KDRID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");
`else
`define KDRID_ASSERT_SAME(lbl, ante, cons)
`define KDRID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/kdrid_pkg.sv */
// ----------------------------------------------------------------------------
// kdrid_pkg
// shared widths, register indexes, reset values and helpers
// ----------------------------------------------------------------------------
`default_nettype none

package kdrid_pkg;

  localparam int KEY_COUNT_DEF = 16;
  localparam int KEY_W         = 16;
  localparam int TIME_W        = 48;
  localparam int LEVEL_W       = 7;
  localparam int HIST_W        = 8;
  localparam int CNT_W         = 4;
  localparam int TGT_W         = 4;
  localparam int TIMEOUT_W     = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMAP_TABLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 2'd3;

  localparam logic [CNT_W-1:0]      PRESS_COUNT_RST   = 4'd2;
  localparam logic [CNT_W-1:0]      RELEASE_COUNT_RST = 4'd2;
  localparam logic [CFG_DATA_W-1:0] REMAP_TABLE_RST   = 64'hFEDC_BA98_7654_3210;
  localparam logic [TIMEOUT_W-1:0]  IDLE_TIMEOUT_RST  = 32'd30_000_000;

  localparam logic [HIST_W-1:0]  HIST_RST  = 8'hFF;
  localparam logic [LEVEL_W-1:0] DIM_FLOOR = 7'd5;

  typedef struct packed {
    logic [HIST_W-1:0] press_mask;
    logic [HIST_W-1:0] release_mask;
  } deb_cfg_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [LEVEL_W-1:0] cmd_level;
    logic               dimmed;
  } idle_res_t;

  // count of 0 acts as 1, above 8 acts as 8
  function automatic logic [HIST_W-1:0] count_mask(input logic [CNT_W-1:0] cnt);
    logic [HIST_W-1:0] m;
    case (cnt) inside
      4'd0, 4'd1: m = 8'h01;
      4'd2:       m = 8'h03;
      4'd3:       m = 8'h07;
      4'd4:       m = 8'h0F;
      4'd5:       m = 8'h1F;
      4'd6:       m = 8'h3F;
      4'd7:       m = 8'h7F;
      default:    m = 8'hFF;
    endcase
    return m;
  endfunction

  // exact floor(x/5) for 7-bit x via reciprocal 205/1024
  function automatic logic [LEVEL_W-1:0] div5(input logic [LEVEL_W-1:0] x);
    logic [16:0] p;
    p = 17'(x) * 17'd205;
    return p[16:10];
  endfunction

endpackage

`default_nettype wire

/* src/kdrid_debounce.sv */
// ----------------------------------------------------------------------------
// kdrid_debounce
// per-key 8-sample shift history and held mask
// ----------------------------------------------------------------------------
`default_nettype none

module kdrid_debounce #(
  parameter int KEY_COUNT = kdrid_pkg::KEY_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [kdrid_pkg::KEY_W-1:0] raw_keys,
  input  wire kdrid_pkg::deb_cfg_t         cfg,
  output logic      [kdrid_pkg::KEY_W-1:0] held_nxt
);

  logic [kdrid_pkg::HIST_W-1:0] hist_r   [KEY_COUNT];
  logic [kdrid_pkg::HIST_W-1:0] hist_nxt [KEY_COUNT];
  logic [kdrid_pkg::KEY_W-1:0]  held_r;

  for (genvar i = 0; i < kdrid_pkg::KEY_W; i++) begin : g_key
    if (i < KEY_COUNT) begin : g_live
      assign hist_nxt[i] = {hist_r[i][kdrid_pkg::HIST_W-2:0], raw_keys[i]};

      assign held_nxt[i] =
        ((hist_nxt[i] & cfg.press_mask) == cfg.press_mask) ? 1'b1 :
        ((hist_nxt[i] & cfg.release_mask) == '0)           ? 1'b0 :
                                                             held_r[i];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          hist_r[i] <= kdrid_pkg::HIST_RST;
        end else if (en) begin
          hist_r[i] <= hist_nxt[i];
        end
      end
    end else begin : g_none
      assign held_nxt[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (en) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/kdrid_remap.sv */
// ----------------------------------------------------------------------------
// kdrid_remap
// maps each held key onto the target bit named by its table entry
// ----------------------------------------------------------------------------
`default_nettype none

module kdrid_remap #(
  parameter int KEY_COUNT = kdrid_pkg::KEY_COUNT_DEF
) (
  input  wire logic [kdrid_pkg::KEY_W-1:0]      held,
  input  wire logic [kdrid_pkg::CFG_DATA_W-1:0] remap_table,
  output logic      [kdrid_pkg::KEY_W-1:0]      remapped
);

  always_comb begin
    logic [kdrid_pkg::TGT_W-1:0] tgt;
    remapped = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      tgt = remap_table[kdrid_pkg::TGT_W*i +: kdrid_pkg::TGT_W];
      // out-of-range target maps the key to itself
      if ({1'b0, tgt} >= 5'(KEY_COUNT)) begin
        tgt = kdrid_pkg::TGT_W'(i);
      end
      if (held[i]) begin
        remapped[tgt] = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/kdrid_idle.sv */
// ----------------------------------------------------------------------------
// kdrid_idle
// idle timer, backlight dim and restore commands
// ----------------------------------------------------------------------------
`default_nettype none

module kdrid_idle (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            any_held,
  input  wire logic [kdrid_pkg::TIME_W-1:0]    now_us,
  input  wire logic [kdrid_pkg::LEVEL_W-1:0]   level,
  input  wire logic [kdrid_pkg::TIMEOUT_W-1:0] idle_timeout_us,
  output kdrid_pkg::idle_res_t                 res
);

  logic [kdrid_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic                          dimmed_r, dimmed_nxt;
  logic [kdrid_pkg::LEVEL_W-1:0] saved_r, saved_nxt;
  logic [kdrid_pkg::TIME_W-1:0]  elapsed;
  logic [kdrid_pkg::LEVEL_W-1:0] dim_level;
  logic                          expired;

  assign elapsed = now_us - last_r;
  assign expired = !dimmed_r && (last_r != '0) && (now_us > last_r) &&
                   (elapsed > kdrid_pkg::TIME_W'(idle_timeout_us));

  always_comb begin
    dim_level = kdrid_pkg::div5(level);
    if (dim_level < kdrid_pkg::DIM_FLOOR) begin
      dim_level = kdrid_pkg::DIM_FLOOR;
    end
  end

  always_comb begin
    last_nxt      = last_r;
    dimmed_nxt    = dimmed_r;
    saved_nxt     = saved_r;
    res.cmd_valid = 1'b0;
    res.cmd_level = '0;
    if (any_held) begin
      last_nxt = now_us;
      if (dimmed_r) begin
        res.cmd_valid = 1'b1;
        res.cmd_level = saved_r;
        dimmed_nxt    = 1'b0;
      end
    end else if (expired) begin
      saved_nxt     = level;
      res.cmd_valid = 1'b1;
      res.cmd_level = dim_level;
      dimmed_nxt    = 1'b1;
    end
    res.dimmed = dimmed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      dimmed_r <= 1'b0;
      saved_r  <= '0;
    end else if (en) begin
      last_r   <= last_nxt;
      dimmed_r <= dimmed_nxt;
      saved_r  <= saved_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/key_debounce_remap_idle_dim.sv */
// ----------------------------------------------------------------------------
// key_debounce_remap_idle_dim
// key debounce with remap and idle backlight dimming, one result word per poll
//
//   channel  direction  handshake            payload
//   in_      sink       in_valid / in_stall  raw_keys, now_us, backlight_level
//   out_     source     out_valid/out_stall  debounced, remapped, backlight cmd
//   cfg_     sink       cfg_we               cfg_index, cfg_wdata
//
// one word per cycle sustained while out_stall is low; a taken word passes the input
// register and then the result register, where out_valid marks it for the sink
// reset is synchronous; history and idle state are ready right after it
// out_stall reaches in_stall combinationally when both stages hold a word
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_debounce_remap_idle_dim_macros.svh"

module key_debounce_remap_idle_dim #(
  parameter int KEY_COUNT = kdrid_pkg::KEY_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,

  input  wire logic                              cfg_we,
  input  wire logic [kdrid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kdrid_pkg::CFG_DATA_W-1:0]  cfg_wdata,

  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [kdrid_pkg::KEY_W-1:0]       in_raw_keys,
  input  wire logic [kdrid_pkg::TIME_W-1:0]      in_now_us,
  input  wire logic [kdrid_pkg::LEVEL_W-1:0]     in_backlight_level,

  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [kdrid_pkg::KEY_W-1:0]       out_debounced_keys,
  output logic      [kdrid_pkg::KEY_W-1:0]       out_remapped_keys,
  output logic                                   out_backlight_cmd_valid,
  output logic      [kdrid_pkg::LEVEL_W-1:0]     out_backlight_cmd_level,
  output logic                                   out_is_dimmed
);

  // configuration
  logic [kdrid_pkg::CNT_W-1:0]      press_count_r;
  logic [kdrid_pkg::CNT_W-1:0]      release_count_r;
  logic [kdrid_pkg::CFG_DATA_W-1:0] remap_table_r;
  logic [kdrid_pkg::TIMEOUT_W-1:0]  idle_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_count_r   <= kdrid_pkg::PRESS_COUNT_RST;
      release_count_r <= kdrid_pkg::RELEASE_COUNT_RST;
      remap_table_r   <= kdrid_pkg::REMAP_TABLE_RST;
      idle_timeout_r  <= kdrid_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdrid_pkg::REG_PRESS_COUNT:   press_count_r   <= cfg_wdata[kdrid_pkg::CNT_W-1:0];
        kdrid_pkg::REG_RELEASE_COUNT: release_count_r <= cfg_wdata[kdrid_pkg::CNT_W-1:0];
        kdrid_pkg::REG_REMAP_TABLE:   remap_table_r   <= cfg_wdata;
        kdrid_pkg::REG_IDLE_TIMEOUT:  idle_timeout_r  <= cfg_wdata[kdrid_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  kdrid_pkg::deb_cfg_t deb_cfg;
  assign deb_cfg.press_mask   = kdrid_pkg::count_mask(press_count_r);
  assign deb_cfg.release_mask = kdrid_pkg::count_mask(release_count_r);

  // input register
  logic                            s1_valid_r;
  logic [kdrid_pkg::KEY_W-1:0]     s1_raw_r;
  logic [kdrid_pkg::TIME_W-1:0]    s1_now_r;
  logic [kdrid_pkg::LEVEL_W-1:0]   s1_level_r;
  logic                            s1_adv;
  logic                            step;
  logic                            in_take;

  assign s1_adv   = !out_valid || !out_stall;
  assign step     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r   <= in_raw_keys;
      s1_now_r   <= in_now_us;
      s1_level_r <= in_backlight_level;
    end
  end

  // processing
  logic [kdrid_pkg::KEY_W-1:0] held_nxt;
  logic [kdrid_pkg::KEY_W-1:0] remapped;
  kdrid_pkg::idle_res_t        idle_res;

  kdrid_debounce #(
    .KEY_COUNT (KEY_COUNT)
  ) u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (step),
    .raw_keys (s1_raw_r),
    .cfg      (deb_cfg),
    .held_nxt (held_nxt)
  );

  kdrid_remap #(
    .KEY_COUNT (KEY_COUNT)
  ) u_remap (
    .held        (held_nxt),
    .remap_table (remap_table_r),
    .remapped    (remapped)
  );

  kdrid_idle u_idle (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (step),
    .any_held        (held_nxt != '0),
    .now_us          (s1_now_r),
    .level           (s1_level_r),
    .idle_timeout_us (idle_timeout_r),
    .res             (idle_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_debounced_keys      <= held_nxt;
      out_remapped_keys       <= remapped;
      out_backlight_cmd_valid <= idle_res.cmd_valid;
      out_backlight_cmd_level <= idle_res.cmd_level;
      out_is_dimmed           <= idle_res.dimmed;
    end
  end

  // checks
  `KDRID_ASSERT_SAME(a_no_cmd_zero_level,
    out_valid && !out_backlight_cmd_valid, out_backlight_cmd_level == '0)
  `KDRID_ASSERT_SAME(a_dim_level_floor,
    out_valid && out_backlight_cmd_valid && out_is_dimmed,
    out_backlight_cmd_level >= kdrid_pkg::DIM_FLOOR)
  `KDRID_ASSERT_SAME(a_restore_needs_key,
    out_valid && out_backlight_cmd_valid && !out_is_dimmed,
    out_debounced_keys != '0)
  `KDRID_ASSERT_SAME(a_remap_nonempty,
    out_valid, (out_debounced_keys == '0) == (out_remapped_keys == '0))
  `KDRID_ASSERT_NEXT(a_stall_holds_input,
    in_stall, s1_valid_r)

endmodule

`default_nettype wire
